// ===== hdl/fed_pkg.sv =====
// Shared types and constants for the feedback echo delay line.
// No dependencies; imported by feedback_echo_delay_line and its testbench.
package fed_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int DEF_RING_DEPTH      = 65536;
    localparam int DEF_SAMPLES_PER_MS  = 48;
    localparam int DELAY_STEP_MS       = 5;
    localparam int DELAY_SETTING_W     = 8;
    localparam int DELAY_CODES         = 1 << DELAY_SETTING_W;
    localparam int CFG_INDEX_W         = 4;
    localparam int CFG_DATA_W          = 8;
    localparam int OUT_QUEUE_DEPTH     = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [1:0]                 mode_t;

    localparam mode_t MODE_OFF  = 2'd0;
    localparam mode_t MODE_PASS = 2'd1;
    localparam mode_t MODE_ECHO = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_MODE   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SETTING = 4'd1;

    // Arithmetic halving: shift right by one, keeping the sign bit.
    function automatic sample_t half_arith(input sample_t v);
        return {v[SAMPLE_W-1], v[SAMPLE_W-1:1]};
    endfunction

endpackage

// ===== hdl/feedback_echo_delay_line.sv =====
// Feedback echo delay line: ring memory, read-modify-write pipeline and output queue.
// Depends on fed_pkg.
//
// Usage. Samples (signed 16 bits, left and right interleaved) arrive on the
// s_axis channel; processed samples leave on m_axis. The cfg channel writes
// register 0 (effect mode: off, passthrough, echo) and register 1 (delay in
// 5 ms steps); cfg_ready is always high. Writes are made while idle by the
// user; the block does not enforce it. In off mode an input transfer is taken
// and dropped, and the ring is left untouched. In passthrough mode the sample
// is stored and returned as is. In echo mode the stored and returned sample is
// the input plus half the ring entry written 240*setting+1 slots earlier,
// wrapping to 16 bits. m_axis_tvalid rises once the sample has passed stage 1
// and entered the output queue; one sample is taken every cycle while
// s_axis_tready is high. The ring is a single-port-read, single-port-write
// memory read in the cycle of the input transfer and written in the cycle
// after; a read of the slot being written is forwarded from the pipeline.
// A three-entry output queue absorbs receiver stalls: s_axis_tready drops
// only when the queue and the pipeline stage together could fill it.
// Reset empties the pipeline and queue, clears the registers and the write
// pointer, and marks the whole ring as zero through a fill count, so no
// clearing pass is needed and samples are taken straight after reset.
module feedback_echo_delay_line #(
    parameter int RING_DEPTH     = fed_pkg::DEF_RING_DEPTH,
    parameter int SAMPLES_PER_MS = fed_pkg::DEF_SAMPLES_PER_MS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fed_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [15:0] sample_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fed_pkg::SAMPLE_W-1:0]      m_axis_tdata,   // [15:0] sample_out
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fed_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fed_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fed_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [AW-1:0] BACK_RESET = AW'(1 % RING_DEPTH);
    localparam int QW = $clog2(OUT_QUEUE_DEPTH);
    localparam logic [QW:0] QCAP = (QW+1)'(OUT_QUEUE_DEPTH);
    localparam logic [QW-1:0] QLAST = QW'(OUT_QUEUE_DEPTH - 1);

    // Read-back distance (D modulo ring depth) for every delay setting.
    logic [AW-1:0] back_tab [DELAY_CODES];
    for (genvar g = 0; g < DELAY_CODES; g++) begin : g_back
        assign back_tab[g] = AW'((SAMPLES_PER_MS * DELAY_STEP_MS * g + 1) % RING_DEPTH);
    end

    // Configuration
    mode_t         mode_reg, mode_next;
    logic [AW-1:0] back_reg, back_next;

    // Pointer and fill count
    logic [AW-1:0] wi_reg, wi_next;
    logic [FW-1:0] fill_reg, fill_next;

    // Stage 1 (memory data available)
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_echo_reg;
    logic          s1_known_reg;
    logic          fwd_hit_reg;
    sample_t       fwd_data_reg;
    sample_t       s1_x_reg;
    logic [AW-1:0] s1_waddr_reg;
    sample_t       rd_data_reg;

    // Output queue
    sample_t       q_mem [OUT_QUEUE_DEPTH];
    logic [QW-1:0] q_head_reg, q_head_next;
    logic [QW-1:0] q_tail_reg, q_tail_next;
    logic [QW:0]   q_count_reg, q_count_next;

    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

    logic          in_xfer, out_xfer, cfg_xfer, do_store;
    logic [AW:0]   raddr_diff;
    logic [AW-1:0] raddr;
    logic          raddr_known;
    logic          fwd_hit;
    sample_t       past, s1_y;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign do_store = in_xfer && (mode_reg != MODE_OFF);

    // Read slot is (write pointer - distance) modulo the ring depth.
    assign raddr_diff = {1'b0, wi_reg} - {1'b0, back_reg};
    assign raddr = raddr_diff[AW] ? AW'(raddr_diff + (AW+1)'(RING_DEPTH)) : raddr_diff[AW-1:0];
    // Slots at or beyond the fill count were never written and read as zero.
    assign raddr_known = (FW'(raddr) < fill_reg);
    assign fwd_hit = s1_valid_reg && (s1_waddr_reg == raddr);

    assign past = fwd_hit_reg ? fwd_data_reg
                : (s1_known_reg ? rd_data_reg : '0);
    assign s1_y = s1_echo_reg ? sample_t'(s1_x_reg + half_arith(past)) : s1_x_reg;

    // The queue must hold the stage 1 sample and the next one even if nothing drains.
    assign s_axis_tready = ((q_count_reg + (QW+1)'(s1_valid_reg)) < QCAP);
    assign m_axis_tvalid = (q_count_reg != '0);
    assign m_axis_tdata  = q_mem[q_head_reg];

    always_comb
    begin
        mode_next = mode_reg;
        back_next = back_reg;
        if (cfg_xfer)
        begin
            if (cfg_index == REG_EFFECT_MODE)
                mode_next = mode_t'(cfg_data[1:0]);
            else if (cfg_index == REG_DELAY_SETTING)
                back_next = back_tab[cfg_data];
        end
    end

    always_comb
    begin
        wi_next       = wi_reg;
        fill_next     = fill_reg;
        s1_valid_next = do_store;
        if (do_store)
        begin
            wi_next = (wi_reg == LAST_SLOT) ? '0 : wi_reg + AW'(1);
            if (fill_reg != DEPTH_F)
                fill_next = fill_reg + FW'(1);
        end
    end

    always_comb
    begin
        q_head_next  = q_head_reg;
        q_tail_next  = q_tail_reg;
        q_count_next = q_count_reg;
        if (s1_valid_reg)
            q_tail_next = (q_tail_reg == QLAST) ? '0 : q_tail_reg + QW'(1);
        if (out_xfer)
            q_head_next = (q_head_reg == QLAST) ? '0 : q_head_reg + QW'(1);
        unique case ({s1_valid_reg, out_xfer})
            2'b10:   q_count_next = q_count_reg + (QW+1)'(1);
            2'b01:   q_count_next = q_count_reg - (QW+1)'(1);
            default: q_count_next = q_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OFF;
            back_reg     <= BACK_RESET;
            wi_reg       <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            q_head_reg   <= '0;
            q_tail_reg   <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            back_reg     <= back_next;
            wi_reg       <= wi_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
            q_head_reg   <= q_head_next;
            q_tail_reg   <= q_tail_next;
            q_count_reg  <= q_count_next;
        end
    end

    // Payload of stage 1; forwarding covers a read of the slot stage 1 writes now.
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            s1_x_reg     <= sample_t'(s_axis_tdata);
            s1_waddr_reg <= wi_reg;
            s1_echo_reg  <= (mode_reg != MODE_PASS);
            s1_known_reg <= raddr_known;
            fwd_hit_reg  <= fwd_hit;
            fwd_data_reg <= s1_y;
        end
        if (s1_valid_reg)
            q_mem[q_tail_reg] <= s1_y;
    end

    // Ring memory: registered read, read-before-write on a shared slot.
    always_ff @(posedge clk)
    begin
        if (do_store)
            rd_data_reg <= sample_t'(ring_mem[raddr]);
        if (s1_valid_reg)
            ring_mem[s1_waddr_reg] <= s1_y;
    end

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_count_reg == QCAP && s1_valid_reg && !out_xfer))
        else $error("output queue overflow");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_F)
        else $error("fill count beyond ring depth");

    a_off_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode_reg == MODE_OFF) |=> !s1_valid_reg)
        else $error("sample stored in off mode");

    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (wi_reg == ((s1_waddr_reg == LAST_SLOT) ? '0
                                     : s1_waddr_reg + AW'(1))))
        else $error("write pointer out of step with pipeline");

    a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != DEPTH_F) |-> (FW'(wi_reg) == fill_reg))
        else $error("fill count and write pointer disagree");

endmodule

// ===== tb/sv/feedback_echo_delay_line_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the feedback echo delay line: stream driver and monitor,
// with a predictor of the ring and write pointer. Depends on fed_pkg and the RTL.
module feedback_echo_delay_line_tb;

    import fed_pkg::*;

    localparam int    SETTLE_CYCLES  = 8;
    localparam int    LONG_HOLD      = 200;
    localparam int    WATCHDOG_LIMIT = 5000;
    localparam int    EXTREME_PCT    = 10;
    // Code three is not named by the design; it behaves as echo.
    localparam mode_t MODE_CODE3     = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 4'hF;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]    m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // Predictor state.
    logic [SAMPLE_W-1:0]        history [DEF_RING_DEPTH];
    int                         wr_ptr    = 0;
    mode_t                      cur_mode  = MODE_OFF;
    logic [DELAY_SETTING_W-1:0] cur_delay = '0;

    logic [SAMPLE_W-1:0] samples_to_send [$];
    logic [SAMPLE_W-1:0] expected_samples [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    bit long_hold_armed = 1'b0;
    int hold_count      = 0;
    int quiet_cycles    = 0;
    int mismatch_count  = 0;

    feedback_echo_delay_line dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the stored and returned sample for one accepted input.
    function automatic void process_sample(input logic [SAMPLE_W-1:0] x);
        logic [SAMPLE_W-1:0] past;
        logic [SAMPLE_W-1:0] y;
        int                  span;
        int                  rd_ptr;
        if (cur_mode == MODE_OFF)
            return;
        if (cur_mode == MODE_PASS)
        begin
            y = x;
        end
        else
        begin
            span   = (DEF_SAMPLES_PER_MS * DELAY_STEP_MS * int'(cur_delay) + 1) % DEF_RING_DEPTH;
            rd_ptr = (wr_ptr + DEF_RING_DEPTH - span) % DEF_RING_DEPTH;
            past   = history[rd_ptr];
            y      = x + {past[SAMPLE_W-1], past[SAMPLE_W-1:1]};
        end
        history[wr_ptr] = y;
        wr_ptr          = (wr_ptr + 1) % DEF_RING_DEPTH;
        expected_samples.push_back(y);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(99) < EXTREME_PCT)
        begin
            case ($urandom_range(3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return SAMPLE_W'($urandom());
    endfunction

    // Driver: a new sample is offered once the previous transfer has completed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata  <= samples_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or one long hold-off counted here while armed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_count    <= 0;
        end
        else if (long_hold_armed && hold_count < LONG_HOLD)
        begin
            m_axis_tready <= 1'b0;
            hold_count    <= hold_count + 1;
        end
        else
        begin
            if (!long_hold_armed)
                hold_count <= 0;
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on input transfers, checks output transfers, runs the watchdog.
    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                process_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample_out, expected none, got %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: sample_out mismatch, expected %h, got %h",
                                 $time, want, m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles, %0d samples outstanding",
                             $time, quiet_cycles, expected_samples.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_EFFECT_MODE)
            cur_mode = val[1:0];
        else if (idx == REG_DELAY_SETTING)
            cur_delay = val;
    endtask

    // Returns at a falling edge once nothing is queued, offered or awaited,
    // then waits SETTLE_CYCLES more for samples dropped in off mode.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || s_axis_tvalid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int s_idle, input int r_stall);
        @(negedge clk);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        repeat (count) samples_to_send.push_back(pick_sample());
        wait_drained();
    endtask

    initial
    begin
        logic [DELAY_SETTING_W-1:0] delay_pick;
        foreach (history[i])
            history[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Off after reset: samples are taken and dropped.
        @(negedge clk);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h8000);
        samples_to_send.push_back(16'h1234);
        wait_drained();

        // Writes to unused indexes must leave the block off.
        write_reg(REG_UNUSED_FIRST, 8'h01);
        write_reg(REG_UNUSED_LAST, 8'hFF);
        @(negedge clk);
        samples_to_send.push_back(16'h0F0F);
        samples_to_send.push_back(16'hF0F0);
        wait_drained();

        write_reg(REG_EFFECT_MODE, {6'd0, MODE_PASS});
        @(negedge clk);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h8000);
        samples_to_send.push_back(16'h0000);
        samples_to_send.push_back(16'hFFFF);
        samples_to_send.push_back(16'h5555);
        samples_to_send.push_back(16'hAAAA);
        wait_drained();

        // Echo of the previous slot; the sum overflows in both directions.
        write_reg(REG_EFFECT_MODE, {6'd0, MODE_ECHO});
        @(negedge clk);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h8000);
        samples_to_send.push_back(16'h8000);
        samples_to_send.push_back(16'h0001);
        samples_to_send.push_back(16'hFFFF);
        wait_drained();

        // Longest delay reads across the ring boundary; code three acts as echo.
        write_reg(REG_DELAY_SETTING, 8'hFF);
        write_reg(REG_EFFECT_MODE, {6'd0, MODE_CODE3});
        @(negedge clk);
        samples_to_send.push_back(16'h4000);
        samples_to_send.push_back(16'hC000);
        samples_to_send.push_back(16'h1234);
        wait_drained();

        // Upper data bits set, mode field off: the ring must stay untouched.
        write_reg(REG_EFFECT_MODE, {6'h3F, MODE_OFF});
        @(negedge clk);
        samples_to_send.push_back(16'h7FFF);
        samples_to_send.push_back(16'h8000);
        wait_drained();

        write_reg(REG_DELAY_SETTING, 8'h00);
        write_reg(REG_EFFECT_MODE, {6'h2A, MODE_PASS});
        run_phase(120, 0, 0);
        write_reg(REG_EFFECT_MODE, {6'd0, MODE_ECHO});
        run_phase(150, 73, 0);
        write_reg(REG_DELAY_SETTING, 8'h01);
        run_phase(260, 0, 73);
        run_phase(150, 30, 30);

        // Receiver holds off while the sender keeps offering, so the input stalls.
        write_reg(REG_DELAY_SETTING, 8'h00);
        @(negedge clk);
        long_hold_armed = 1'b1;
        run_phase(80, 0, 0);
        long_hold_armed = 1'b0;

        write_reg(REG_EFFECT_MODE, {6'd0, MODE_OFF});
        run_phase(30, 30, 30);
        delay_pick = DELAY_SETTING_W'($urandom_range(4, 2));
        write_reg(REG_DELAY_SETTING, delay_pick);
        write_reg(REG_EFFECT_MODE, {6'd0, MODE_CODE3});
        run_phase(180, 30, 30);
        write_reg(REG_DELAY_SETTING, 8'hFF);
        write_reg(REG_EFFECT_MODE, {6'd0, MODE_ECHO});
        run_phase(60, 73, 73);
        write_reg(REG_EFFECT_MODE, {6'd0, MODE_PASS});
        run_phase(50, 0, 0);

        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
